// ===== rtl/vup_pkg.sv =====
// ----------------------------------------------------------------------------
// vup_pkg
// Shared types and constants of the video unit register port.
// ----------------------------------------------------------------------------
`default_nettype none

package vup_pkg;

	// Default sizes of the two memories
	localparam int VRAM_ADDR_BITS_DEF = 14;
	localparam int OAM_BYTES_DEF      = 256;

	// Field widths
	localparam int ADDR_W = 15;
	localparam int BYTE_W = 8;

	// Reset values of the control and mask registers
	localparam logic [BYTE_W-1:0] CTRL_RESET = 8'h90;
	localparam logic [BYTE_W-1:0] MASK_RESET = 8'h18;

	// Access direction
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Top six bits of a 14-bit address in palette space
	localparam logic [5:0] PALETTE_PAGE = 6'h3F;

	// Coarse Y values with special wrap behavior
	localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
	localparam logic [4:0] COARSE_Y_MAX      = 5'd31;

	// Register numbers
	typedef enum logic [2:0] {
		REG_CTRL     = 3'd0,
		REG_MASK     = 3'd1,
		REG_STATUS   = 3'd2,
		REG_OAM_ADDR = 3'd3,
		REG_OAM_DATA = 3'd4,
		REG_SCROLL   = 3'd5,
		REG_ADDR     = 3'd6,
		REG_DATA     = 3'd7
	} reg_sel_t;

	// Where the bus latch of an access in flight comes from
	typedef enum logic [1:0] {
		LATCH_KNOWN  = 2'd0, // latch value already settled at transfer
		LATCH_OAM    = 2'd1, // sprite memory read data
		LATCH_VRAM   = 2'd2, // video memory read data (palette space)
		LATCH_REFILL = 2'd3  // old buffer to latch, video data to buffer
	} latch_src_t;

endpackage

`default_nettype wire

// ===== rtl/vup_req_if.sv =====
// ----------------------------------------------------------------------------
// vup_req_if
// Bus access channel: one register read or write per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vup_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [2:0] reg_select;
	logic [7:0] write_data;
	logic       rendering_active;
	logic       writes_locked;
	logic [2:0] status_bits;

	modport source (
		output valid, mode, reg_select, write_data, rendering_active,
		       writes_locked, status_bits,
		input  ready
	);

	modport sink (
		input  valid, mode, reg_select, write_data, rendering_active,
		       writes_locked, status_bits,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/vup_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vup_rsp_if
// Result channel: bus latch and register state after each access.
// ----------------------------------------------------------------------------
`default_nettype none

interface vup_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [14:0] vram_pointer;
	logic [14:0] temp_pointer;
	logic [2:0]  fine_scroll_x;
	logic [7:0]  control_byte;
	logic [7:0]  mask_byte;
	logic [7:0]  sprite_pointer;

	modport source (
		output valid, read_data, vram_pointer, temp_pointer, fine_scroll_x,
		       control_byte, mask_byte, sprite_pointer,
		input  ready
	);

	modport sink (
		input  valid, read_data, vram_pointer, temp_pointer, fine_scroll_x,
		       control_byte, mask_byte, sprite_pointer,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/vup_ram.sv =====
// ----------------------------------------------------------------------------
// vup_ram
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vup_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic [7:0]         rdata
);
	logic [7:0] mem [DEPTH];

	// Write on request, register read data on request
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

`default_nettype wire

// ===== rtl/vup_addr_step.sv =====
// ----------------------------------------------------------------------------
// vup_addr_step
// Next video address after a data access: +1 / +32 when idle,
// coarse X step followed by Y step while rendering.
// ----------------------------------------------------------------------------
`default_nettype none

module vup_addr_step (
	input  wire logic [vup_pkg::ADDR_W-1:0] addr,
	input  wire logic                       rendering,
	input  wire logic                       inc32,
	output logic [vup_pkg::ADDR_W-1:0]      next_addr
);
	import vup_pkg::*;

	logic [ADDR_W-1:0] ax;
	logic [ADDR_W-1:0] ay;
	logic [4:0]        cy;

	always_comb begin
		// Coarse X step, wrap into the neighbor nametable
		ax = addr;
		if (addr[4:0] == 5'h1F) begin
			ax[4:0] = 5'h00;
			ax[10]  = ~addr[10];
		end else begin
			ax[4:0] = addr[4:0] + 5'd1;
		end

		// Y step: fine Y first, then coarse Y
		ay = ax;
		cy = ax[9:5];
		if (ax[14:12] != 3'h7) begin
			ay[14:12] = ax[14:12] + 3'd1;
		end else begin
			ay[14:12] = 3'h0;
			if (cy == COARSE_Y_LAST_ROW) begin
				cy     = 5'd0;
				ay[11] = ~ax[11];
			end else if (cy == COARSE_Y_MAX) begin
				cy = 5'd0;
			end else begin
				cy = cy + 5'd1;
			end
			ay[9:5] = cy;
		end

		// Pick the step
		if (rendering) begin
			next_addr = ay;
		end else if (inc32) begin
			next_addr = addr + ADDR_W'(32);
		end else begin
			next_addr = addr + ADDR_W'(1);
		end
	end
endmodule

`default_nettype wire

// ===== rtl/video_unit_register_port_unit.sv =====
// ----------------------------------------------------------------------------
// video_unit_register_port_unit
// Register port of a picture unit: control, mask, status, sprite and video
// memory access, scroll and address pair, with rendering left out.
// ----------------------------------------------------------------------------
// Takes one bus access per clock and returns one result per access, in the
// cycle after its transfer. All register updates happen at the transfer;
// the sprite and video memories are read in that same cycle and their
// registered read data settles the bus latch and read buffer of the access
// in the output stage, from where it is forwarded to the next access. The
// output stage holds a result while the sink stalls and takes a new access
// in the cycle it is emptied. There is no clearing pass after reset; memory
// entries read before they are written return unspecified data.
`default_nettype none

module video_unit_register_port_unit #(
	parameter int VRAM_ADDR_BITS = vup_pkg::VRAM_ADDR_BITS_DEF,
	parameter int OAM_BYTES      = vup_pkg::OAM_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vup_req_if.sink   req,
	vup_rsp_if.source rsp
);
	import vup_pkg::*;

	localparam int VRAM_DEPTH = 1 << VRAM_ADDR_BITS;
	localparam int OAM_AW     = $clog2(OAM_BYTES);

	// Architectural registers
	logic [ADDR_W-1:0] cur_addr_q;
	logic [ADDR_W-1:0] tmp_addr_q;
	logic [2:0]        fine_x_q;
	logic              toggle_q;
	logic [BYTE_W-1:0] ctrl_q;
	logic [BYTE_W-1:0] mask_q;
	logic [BYTE_W-1:0] oam_ptr_q;
	logic [BYTE_W-1:0] latch_q;
	logic [BYTE_W-1:0] buf_q;

	// Output stage
	logic              valid_s1;
	latch_src_t        src_s1;
	logic [BYTE_W-1:0] latch_s1;

	// Next values
	logic [ADDR_W-1:0] n_cur;
	logic [ADDR_W-1:0] n_tmp;
	logic [2:0]        n_fx;
	logic              n_toggle;
	logic [BYTE_W-1:0] n_ctrl;
	logic [BYTE_W-1:0] n_mask;
	logic [BYTE_W-1:0] n_oam;
	latch_src_t        n_src;
	logic [BYTE_W-1:0] n_latch;

	logic              accept;
	logic              vram_we;
	logic              vram_re;
	logic              oam_we;
	logic              oam_re;
	logic [BYTE_W-1:0] vram_rdata;
	logic [BYTE_W-1:0] oam_rdata;
	logic [ADDR_W-1:0] step_addr;
	logic [BYTE_W-1:0] oam_mod;
	logic [BYTE_W-1:0] res_latch;
	logic [BYTE_W-1:0] cur_latch;
	logic [BYTE_W-1:0] cur_buf;
	logic [BYTE_W-1:0] d;
	reg_sel_t          sel;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;
	assign d         = req.write_data;
	assign sel       = reg_sel_t'(req.reg_select);

	// Latch and buffer after the access in the output stage
	always_comb begin
		case (src_s1)
			LATCH_OAM:  res_latch = oam_rdata;
			LATCH_VRAM: res_latch = vram_rdata;
			default:    res_latch = latch_s1;
		endcase
	end

	assign cur_latch = valid_s1 ? res_latch : latch_q;
	assign cur_buf   = (valid_s1 && src_s1 == LATCH_REFILL) ? vram_rdata : buf_q;

	// Sprite index: pointer reduced below the memory size
	always_comb begin
		oam_mod = oam_ptr_q;
		for (int i = 0; i < 3; i++) begin
			if ({1'b0, oam_mod} >= 9'(OAM_BYTES)) begin
				oam_mod = oam_mod - 8'(OAM_BYTES);
			end
		end
	end

	vup_addr_step u_step (
		.addr      (cur_addr_q),
		.rendering (req.rendering_active),
		.inc32     (ctrl_q[2]),
		.next_addr (step_addr)
	);

	// Decode the access and compute the register updates
	always_comb begin
		n_cur    = cur_addr_q;
		n_tmp    = tmp_addr_q;
		n_fx     = fine_x_q;
		n_toggle = toggle_q;
		n_ctrl   = ctrl_q;
		n_mask   = mask_q;
		n_oam    = oam_ptr_q;
		n_src    = LATCH_KNOWN;
		n_latch  = cur_latch;
		vram_we  = 1'b0;
		vram_re  = 1'b0;
		oam_we   = 1'b0;
		oam_re   = 1'b0;

		if (req.mode == MODE_WRITE) begin
			n_latch = d;
			unique case (sel)
				REG_CTRL: begin
					if (!req.writes_locked) begin
						n_ctrl        = d;
						n_tmp[11:10]  = d[1:0];
					end
				end
				REG_MASK: begin
					if (!req.writes_locked) begin
						n_mask = d;
					end
				end
				REG_OAM_ADDR: begin
					if (!req.rendering_active) begin
						n_oam = d;
					end
				end
				REG_OAM_DATA: begin
					if (!req.rendering_active) begin
						oam_we = 1'b1;
						n_oam  = oam_ptr_q + 8'd1;
					end
				end
				REG_SCROLL: begin
					if (!req.writes_locked) begin
						if (!toggle_q) begin
							n_tmp[4:0] = d[7:3];
							n_fx       = d[2:0];
							n_toggle   = 1'b1;
						end else begin
							n_tmp[9:5]   = d[7:3];
							n_tmp[14:12] = d[2:0];
							n_toggle     = 1'b0;
						end
					end
				end
				REG_ADDR: begin
					if (!req.writes_locked) begin
						if (!toggle_q) begin
							n_tmp[13:8] = d[5:0];
							n_tmp[14]   = 1'b0;
							n_toggle    = 1'b1;
						end else begin
							n_tmp[7:0] = d;
							n_toggle   = 1'b0;
							n_cur      = {tmp_addr_q[14:8], d};
						end
					end
				end
				REG_DATA: begin
					vram_we = !req.rendering_active;
					n_cur   = step_addr;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (sel)
				REG_STATUS: begin
					n_latch  = {req.status_bits, cur_latch[4:0]};
					n_toggle = 1'b0;
				end
				REG_OAM_DATA: begin
					oam_re = 1'b1;
					n_src  = LATCH_OAM;
				end
				REG_DATA: begin
					vram_re = 1'b1;
					n_cur   = step_addr;
					if (cur_addr_q[13:8] == PALETTE_PAGE) begin
						n_src = LATCH_VRAM;
					end else begin
						n_src   = LATCH_REFILL;
						n_latch = cur_buf;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Video memory
	vup_ram #(
		.DEPTH (VRAM_DEPTH),
		.AW    (VRAM_ADDR_BITS)
	) u_vram (
		.clk   (clk),
		.we    (accept && vram_we),
		.re    (accept && vram_re),
		.addr  (VRAM_ADDR_BITS'(cur_addr_q)),
		.wdata (d),
		.rdata (vram_rdata)
	);

	// Sprite memory
	vup_ram #(
		.DEPTH (OAM_BYTES),
		.AW    (OAM_AW)
	) u_oam (
		.clk   (clk),
		.we    (accept && oam_we),
		.re    (accept && oam_re),
		.addr  (oam_mod[OAM_AW-1:0]),
		.wdata (d),
		.rdata (oam_rdata)
	);

	// Update registers on transfer, commit latch and buffer from the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= '0;
			tmp_addr_q <= '0;
			fine_x_q   <= '0;
			toggle_q   <= 1'b0;
			ctrl_q     <= CTRL_RESET;
			mask_q     <= MASK_RESET;
			oam_ptr_q  <= '0;
			latch_q    <= '0;
			buf_q      <= '0;
			valid_s1   <= 1'b0;
			src_s1     <= LATCH_KNOWN;
		end else begin
			if (valid_s1) begin
				latch_q <= res_latch;
				buf_q   <= cur_buf;
			end
			if (accept) begin
				cur_addr_q <= n_cur;
				tmp_addr_q <= n_tmp;
				fine_x_q   <= n_fx;
				toggle_q   <= n_toggle;
				ctrl_q     <= n_ctrl;
				mask_q     <= n_mask;
				oam_ptr_q  <= n_oam;
				src_s1     <= n_src;
				valid_s1   <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Hold the settled latch value of the access in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			latch_s1 <= n_latch;
		end
	end

	// Drive the result
	assign rsp.valid          = valid_s1;
	assign rsp.read_data      = res_latch;
	assign rsp.vram_pointer   = cur_addr_q;
	assign rsp.temp_pointer   = tmp_addr_q;
	assign rsp.fine_scroll_x  = fine_x_q;
	assign rsp.control_byte   = ctrl_q;
	assign rsp.mask_byte      = mask_q;
	assign rsp.sprite_pointer = oam_ptr_q;
endmodule

`default_nettype wire
